/* rtl/rlsv_pkg.sv */
// Package for the route local search engine: widths, codes, states and trial index mapping.
`default_nettype none
package rlsv_pkg;

  localparam int NODE_W   = 6;
  localparam int TRUCK_W  = 4;
  localparam int CNT_W    = 5;
  localparam int DIST_W   = 16;
  localparam int DEM_W    = 16;
  localparam int LOAD_W   = 22;
  localparam int COST_W   = 32;
  localparam int ACC_W    = 22;
  localparam int TRUCKS   = 16;
  localparam int RT_AW    = TRUCK_W + NODE_W;
  localparam int DS_AW    = 2 * NODE_W;
  localparam logic [NODE_W-1:0] POS_LIMIT = NODE_W'(63);
  localparam logic [CNT_W-1:0]  MAX_TRUCKS = CNT_W'(TRUCKS);

  localparam logic [2:0] A_DIST  = 3'd0;
  localparam logic [2:0] A_DEM   = 3'd1;
  localparam logic [2:0] A_ENTRY = 3'd2;
  localparam logic [2:0] A_HDR   = 3'd3;
  localparam logic [2:0] A_RUN   = 3'd4;
  localparam logic [2:0] A_RDENT = 3'd5;
  localparam logic [2:0] A_RDHDR = 3'd6;

  localparam logic [1:0] NB_SWAP = 2'd0;
  localparam logic [1:0] NB_XCHG = 2'd1;
  localparam logic [1:0] NB_REV  = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE, S_RDENT, S_DONE,
    S_LD_START, S_LD_ADDR, S_LD_DEM, S_LD_ACC,
    S_NB_START, S_PASS_END,
    S_T_START, S_T_J, S_T_K, S_T_EVAL,
    S_SW_RD1, S_SW_RD2, S_SW_WR1, S_SW_WR2,
    S_X_A, S_X_B, S_X_K, S_X_L,
    S_X_F1, S_X_F2, S_X_F3, S_X_F4, S_X_F5,
    S_X_CA, S_X_EVAL, S_X_W1, S_X_W2,
    S_C_ADDR, S_C_NODE, S_C_ACC
  } state_t;

  // position in the stored route that feeds trial position p
  function automatic logic [NODE_W-1:0] trial_src(input logic [1:0] nbh,
                                                  input logic [NODE_W-1:0] p,
                                                  input logic [NODE_W-1:0] j,
                                                  input logic [NODE_W-1:0] k);
    logic [NODE_W:0] mirror;
    logic [NODE_W-1:0] res;
    mirror = {1'b0, j} + {1'b0, k} - {1'b0, p};
    res = p;
    case (nbh)
      NB_SWAP: begin
        if (p == j) res = k;
        else if (p == k) res = j;
      end
      NB_REV: begin
        if (p >= j && p <= k) res = mirror[NODE_W-1:0];
      end
      default: res = p;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/rlsv_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module rlsv_ram #(
  parameter int AW = 10,
  parameter int DW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/route_local_search_vnd_core.sv */
// Top level of the route local search engine (variable neighborhood descent).
// Input channel in_*: one beat is one command (matrix, demand, route writes,
// run, route reads). Result channel out_*: exactly one beat per command.
// Configuration: cfg_we with cfg_index 0 = truck capacity, 1 = truck count;
// the user must write it only while idle; the block does not enforce this.
// Matrix, demand and header read commands go from accept to the done state
// directly; an entry read passes through a read state first. Route entry and
// header writes then recompute the route load, walking the route client by
// client. A run recomputes all loads, then loops over the three neighborhoods;
// each trial cost walks the route through the route memory and the distance
// memory edge by edge, so run time depends on route lengths and accepted moves.
// in_stall is high from accept until the result is moved to the output
// register; a stalled result stays in the output register while the next
// command is taken. Reset clears the control state and the header tables and
// sets capacity 0, count 1; distance, demand and route memories are not cleared.
`default_nettype none
module route_local_search_vnd_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [21:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [5:0]  in_from_node,
  input  wire logic [5:0]  in_to_node,
  input  wire logic [15:0] in_distance,
  input  wire logic [15:0] in_node_demand,
  input  wire logic [3:0]  in_truck,
  input  wire logic [5:0]  in_position,
  input  wire logic [5:0]  in_client,
  input  wire logic [5:0]  in_route_length,
  input  wire logic [31:0] in_route_cost,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_read_client,
  output logic [5:0]       out_read_length,
  output logic [31:0]      out_read_cost,
  output logic [21:0]      out_read_load,
  output logic             out_improved,
  output logic             out_status
);
  localparam int NW = rlsv_pkg::NODE_W;
  localparam int CW = rlsv_pkg::CNT_W;
  localparam int LW = rlsv_pkg::LOAD_W;
  localparam int KW = rlsv_pkg::COST_W;
  localparam int AW = rlsv_pkg::ACC_W;

  rlsv_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [1:0]    nbh_r, nbh_nxt;
  logic          hit_r, hit_nxt, any_r, any_nxt, ld_one_r, ld_one_nxt;
  logic [CW-1:0] t_r, t_nxt, u_r, u_nxt;
  logic [NW-1:0] j_r, j_nxt, k_r, k_nxt, l_r, l_nxt, p_r, p_nxt, last_r, last_nxt;
  logic [AW-1:0] acc_r, acc_nxt, ca_r, ca_nxt;
  logic [3:0]    ct_r, ct_nxt;
  logic [NW-1:0] clen_r, clen_nxt;
  logic          ov_en_r, ov_en_nxt;
  logic [NW-1:0] ov_pos_r, ov_pos_nxt, ov_val_r, ov_val_nxt;
  logic [NW-1:0] x_r, x_nxt, y_r, y_nxt, sw_x_r, sw_x_nxt;
  logic [NW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [15:0]   dx_r, dx_nxt;
  logic [LW-1:0] da_r, da_nxt, db_r, db_nxt;
  logic [LW-1:0] cap_r;
  logic [CW-1:0] cnt_r;

  logic [NW-1:0] len_r  [rlsv_pkg::TRUCKS];
  logic [NW-1:0] len_nxt[rlsv_pkg::TRUCKS];
  logic [KW-1:0] cost_r [rlsv_pkg::TRUCKS];
  logic [KW-1:0] cost_nxt[rlsv_pkg::TRUCKS];
  logic [LW-1:0] load_r [rlsv_pkg::TRUCKS];
  logic [LW-1:0] load_nxt[rlsv_pkg::TRUCKS];

  logic [NW-1:0] res_client_r, res_client_nxt, res_length_r, res_length_nxt;
  logic [KW-1:0] res_cost_r, res_cost_nxt;
  logic [LW-1:0] res_load_r, res_load_nxt;
  logic          res_imp_r, res_imp_nxt, res_status_r, res_status_nxt;
  logic          out_valid_r;

  logic                     rt_we, dm_we, ds_we;
  logic [rlsv_pkg::RT_AW-1:0] rt_waddr, rt_raddr;
  logic [NW-1:0]            rt_wdata, rt_q;
  logic [NW-1:0]            dm_waddr, dm_raddr;
  logic [15:0]              dm_wdata, dm_q;
  logic [rlsv_pkg::DS_AW-1:0] ds_waddr, ds_raddr;
  logic [15:0]              ds_wdata, ds_q;

  rlsv_ram #(.AW(rlsv_pkg::RT_AW), .DW(NW)) u_route (
    .clk, .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata), .raddr(rt_raddr), .rdata(rt_q));
  rlsv_ram #(.AW(NW), .DW(16)) u_demand (
    .clk, .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata), .raddr(dm_raddr), .rdata(dm_q));
  rlsv_ram #(.AW(rlsv_pkg::DS_AW), .DW(16)) u_dist (
    .clk, .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata), .raddr(ds_raddr), .rdata(ds_q));

  logic          accept, out_free;
  logic [CW-1:0] n_act;
  logic [3:0]    ti, ui;
  logic [NW-1:0] node;
  logic [LW+1:0] da_w, db_w;
  logic [AW:0]   csum;
  logic [KW:0]   osum;
  logic [NW:0]   lo2;

  assign in_stall = (state_r != rlsv_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign n_act    = (cnt_r > rlsv_pkg::MAX_TRUCKS) ? rlsv_pkg::MAX_TRUCKS : cnt_r;
  assign ti       = t_r[3:0];
  assign ui       = u_r[3:0];
  assign node     = (ov_en_r && p_r == ov_pos_r) ? ov_val_r : rt_q;
  assign da_w     = {2'b0, load_r[ti]} - {8'b0, dx_r} + {8'b0, dm_q};
  assign db_w     = {2'b0, load_r[ui]} - {8'b0, dm_q} + {8'b0, dx_r};
  assign csum     = {1'b0, ca_r} + {1'b0, acc_r};
  assign osum     = {1'b0, cost_r[ti]} + {1'b0, cost_r[ui]};
  assign lo2      = {1'b0, lo_r} + (NW+1)'(2);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rlsv_pkg::S_IDLE: begin
        if (accept) begin
          case (in_action)
            rlsv_pkg::A_ENTRY:
              state_nxt = (in_position == rlsv_pkg::POS_LIMIT) ? rlsv_pkg::S_DONE
                                                               : rlsv_pkg::S_LD_START;
            rlsv_pkg::A_HDR, rlsv_pkg::A_RUN: state_nxt = rlsv_pkg::S_LD_START;
            rlsv_pkg::A_RDENT:
              state_nxt = (in_position == rlsv_pkg::POS_LIMIT) ? rlsv_pkg::S_DONE
                                                               : rlsv_pkg::S_RDENT;
            default: state_nxt = rlsv_pkg::S_DONE;
          endcase
        end
      end
      rlsv_pkg::S_RDENT: state_nxt = rlsv_pkg::S_DONE;
      rlsv_pkg::S_DONE: if (out_free) state_nxt = rlsv_pkg::S_IDLE;
      rlsv_pkg::S_LD_START:
        state_nxt = (!ld_one_r && t_r == n_act) ? rlsv_pkg::S_NB_START : rlsv_pkg::S_LD_ADDR;
      rlsv_pkg::S_LD_ADDR: begin
        if (p_r == len_r[ti]) state_nxt = ld_one_r ? rlsv_pkg::S_DONE : rlsv_pkg::S_LD_START;
        else state_nxt = rlsv_pkg::S_LD_DEM;
      end
      rlsv_pkg::S_LD_DEM: state_nxt = rlsv_pkg::S_LD_ACC;
      rlsv_pkg::S_LD_ACC: state_nxt = rlsv_pkg::S_LD_ADDR;
      rlsv_pkg::S_NB_START:
        state_nxt = (nbh_r == rlsv_pkg::NB_XCHG) ? rlsv_pkg::S_X_A : rlsv_pkg::S_T_START;
      rlsv_pkg::S_PASS_END: begin
        if (!hit_r && nbh_r == rlsv_pkg::NB_REV) state_nxt = rlsv_pkg::S_DONE;
        else state_nxt = rlsv_pkg::S_NB_START;
      end
      rlsv_pkg::S_T_START:
        state_nxt = (t_r == n_act) ? rlsv_pkg::S_PASS_END : rlsv_pkg::S_T_J;
      rlsv_pkg::S_T_J:
        state_nxt = (j_r >= len_r[ti]) ? rlsv_pkg::S_T_START : rlsv_pkg::S_T_K;
      rlsv_pkg::S_T_K:
        state_nxt = (k_r >= len_r[ti]) ? rlsv_pkg::S_T_J : rlsv_pkg::S_C_ADDR;
      rlsv_pkg::S_T_EVAL:
        state_nxt = ({10'b0, acc_r} < cost_r[ti]) ? rlsv_pkg::S_SW_RD1 : rlsv_pkg::S_T_K;
      rlsv_pkg::S_SW_RD1: state_nxt = rlsv_pkg::S_SW_RD2;
      rlsv_pkg::S_SW_RD2: state_nxt = rlsv_pkg::S_SW_WR1;
      rlsv_pkg::S_SW_WR1: state_nxt = rlsv_pkg::S_SW_WR2;
      rlsv_pkg::S_SW_WR2:
        state_nxt = (nbh_r == rlsv_pkg::NB_REV && lo2 < {1'b0, hi_r}) ? rlsv_pkg::S_SW_RD1
                                                                       : rlsv_pkg::S_T_K;
      rlsv_pkg::S_X_A: state_nxt = (t_r == n_act) ? rlsv_pkg::S_PASS_END : rlsv_pkg::S_X_B;
      rlsv_pkg::S_X_B: state_nxt = (u_r >= n_act) ? rlsv_pkg::S_X_A : rlsv_pkg::S_X_K;
      rlsv_pkg::S_X_K: state_nxt = (k_r >= len_r[ti]) ? rlsv_pkg::S_X_B : rlsv_pkg::S_X_L;
      rlsv_pkg::S_X_L: state_nxt = (l_r >= len_r[ui]) ? rlsv_pkg::S_X_K : rlsv_pkg::S_X_F1;
      rlsv_pkg::S_X_F1: state_nxt = rlsv_pkg::S_X_F2;
      rlsv_pkg::S_X_F2: state_nxt = rlsv_pkg::S_X_F3;
      rlsv_pkg::S_X_F3: state_nxt = rlsv_pkg::S_X_F4;
      rlsv_pkg::S_X_F4: state_nxt = rlsv_pkg::S_X_F5;
      rlsv_pkg::S_X_F5: begin
        if (da_w > {2'b0, cap_r} || db_w > {2'b0, cap_r}) state_nxt = rlsv_pkg::S_X_L;
        else state_nxt = rlsv_pkg::S_C_ADDR;
      end
      rlsv_pkg::S_X_CA: state_nxt = rlsv_pkg::S_C_ADDR;
      rlsv_pkg::S_X_EVAL:
        state_nxt = ({{(KW-AW){1'b0}}, csum} < osum) ? rlsv_pkg::S_X_W1 : rlsv_pkg::S_X_L;
      rlsv_pkg::S_X_W1: state_nxt = rlsv_pkg::S_X_W2;
      rlsv_pkg::S_X_W2: state_nxt = rlsv_pkg::S_X_L;
      rlsv_pkg::S_C_ADDR: state_nxt = (p_r == clen_r) ? rlsv_pkg::S_C_ACC : rlsv_pkg::S_C_NODE;
      rlsv_pkg::S_C_NODE: state_nxt = rlsv_pkg::S_C_ACC;
      rlsv_pkg::S_C_ACC: state_nxt = (p_r == clen_r) ? ret_r : rlsv_pkg::S_C_ADDR;
      default: state_nxt = rlsv_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ret_nxt = ret_r; nbh_nxt = nbh_r; hit_nxt = hit_r; any_nxt = any_r;
    ld_one_nxt = ld_one_r; t_nxt = t_r; u_nxt = u_r; j_nxt = j_r; k_nxt = k_r;
    l_nxt = l_r; p_nxt = p_r; last_nxt = last_r; acc_nxt = acc_r; ca_nxt = ca_r;
    ct_nxt = ct_r; clen_nxt = clen_r; ov_en_nxt = ov_en_r; ov_pos_nxt = ov_pos_r;
    ov_val_nxt = ov_val_r; x_nxt = x_r; y_nxt = y_r; sw_x_nxt = sw_x_r;
    lo_nxt = lo_r; hi_nxt = hi_r; dx_nxt = dx_r; da_nxt = da_r; db_nxt = db_r;
    len_nxt = len_r; cost_nxt = cost_r; load_nxt = load_r;
    res_client_nxt = res_client_r; res_length_nxt = res_length_r;
    res_cost_nxt = res_cost_r; res_load_nxt = res_load_r;
    res_imp_nxt = res_imp_r; res_status_nxt = res_status_r;
    rt_we = 1'b0; rt_waddr = '0; rt_wdata = '0; rt_raddr = '0;
    dm_we = 1'b0; dm_waddr = '0; dm_wdata = '0; dm_raddr = '0;
    ds_we = 1'b0; ds_waddr = '0; ds_wdata = '0; ds_raddr = '0;
    case (state_r)
      rlsv_pkg::S_IDLE: begin
        if (accept) begin
          res_client_nxt = '0; res_length_nxt = '0; res_cost_nxt = '0;
          res_load_nxt = '0; res_imp_nxt = 1'b0; res_status_nxt = 1'b0;
          t_nxt = {1'b0, in_truck};
          p_nxt = '0; acc_nxt = '0;
          ld_one_nxt = 1'b1;
          case (in_action)
            rlsv_pkg::A_DIST: begin
              ds_we = 1'b1; ds_waddr = {in_from_node, in_to_node}; ds_wdata = in_distance;
            end
            rlsv_pkg::A_DEM: begin
              dm_we = 1'b1; dm_waddr = in_from_node; dm_wdata = in_node_demand;
            end
            rlsv_pkg::A_ENTRY: begin
              if (in_position == rlsv_pkg::POS_LIMIT) res_status_nxt = 1'b1;
              else begin
                rt_we = 1'b1; rt_waddr = {in_truck, in_position}; rt_wdata = in_client;
              end
            end
            rlsv_pkg::A_HDR: begin
              len_nxt[in_truck] = in_route_length;
              cost_nxt[in_truck] = in_route_cost;
            end
            rlsv_pkg::A_RUN: begin
              t_nxt = '0; ld_one_nxt = 1'b0; any_nxt = 1'b0; nbh_nxt = rlsv_pkg::NB_SWAP;
            end
            rlsv_pkg::A_RDENT: begin
              if (in_position == rlsv_pkg::POS_LIMIT) res_status_nxt = 1'b1;
              else rt_raddr = {in_truck, in_position};
            end
            rlsv_pkg::A_RDHDR: begin
              res_length_nxt = len_r[in_truck];
              res_cost_nxt = cost_r[in_truck];
              res_load_nxt = load_r[in_truck];
            end
            default: res_status_nxt = 1'b1;
          endcase
        end
      end
      rlsv_pkg::S_RDENT: res_client_nxt = rt_q;
      rlsv_pkg::S_LD_START: begin
        p_nxt = '0; acc_nxt = '0;
      end
      rlsv_pkg::S_LD_ADDR: begin
        if (p_r == len_r[ti]) begin
          load_nxt[ti] = acc_r;
          t_nxt = t_r + CW'(1);
        end else rt_raddr = {ti, p_r};
      end
      rlsv_pkg::S_LD_DEM: dm_raddr = rt_q;
      rlsv_pkg::S_LD_ACC: begin
        acc_nxt = acc_r + {{(AW-16){1'b0}}, dm_q};
        p_nxt = p_r + NW'(1);
      end
      rlsv_pkg::S_NB_START: begin
        hit_nxt = 1'b0; t_nxt = '0;
      end
      rlsv_pkg::S_PASS_END: begin
        if (hit_r) begin
          any_nxt = 1'b1; nbh_nxt = rlsv_pkg::NB_SWAP;
        end else if (nbh_r == rlsv_pkg::NB_REV) begin
          nbh_nxt = rlsv_pkg::NB_SWAP; res_imp_nxt = any_r;
        end else nbh_nxt = nbh_r + 2'd1;
      end
      rlsv_pkg::S_T_START: j_nxt = '0;
      rlsv_pkg::S_T_J: begin
        if (j_r >= len_r[ti]) t_nxt = t_r + CW'(1);
        else k_nxt = (nbh_r == rlsv_pkg::NB_SWAP) ? '0 : j_r + NW'(1);
      end
      rlsv_pkg::S_T_K: begin
        if (k_r >= len_r[ti]) j_nxt = j_r + NW'(1);
        else begin
          ct_nxt = ti; clen_nxt = len_r[ti]; ov_en_nxt = 1'b0;
          p_nxt = '0; last_nxt = '0; acc_nxt = '0; ret_nxt = rlsv_pkg::S_T_EVAL;
        end
      end
      rlsv_pkg::S_T_EVAL: begin
        if ({10'b0, acc_r} < cost_r[ti]) begin
          cost_nxt[ti] = {10'b0, acc_r};
          hit_nxt = 1'b1; lo_nxt = j_r; hi_nxt = k_r;
        end else k_nxt = k_r + NW'(1);
      end
      rlsv_pkg::S_SW_RD1: rt_raddr = {ti, lo_r};
      rlsv_pkg::S_SW_RD2: begin
        sw_x_nxt = rt_q; rt_raddr = {ti, hi_r};
      end
      rlsv_pkg::S_SW_WR1: begin
        rt_we = 1'b1; rt_waddr = {ti, lo_r}; rt_wdata = rt_q;
      end
      rlsv_pkg::S_SW_WR2: begin
        rt_we = 1'b1; rt_waddr = {ti, hi_r}; rt_wdata = sw_x_r;
        if (nbh_r == rlsv_pkg::NB_REV && lo2 < {1'b0, hi_r}) begin
          lo_nxt = lo_r + NW'(1); hi_nxt = hi_r - NW'(1);
        end else k_nxt = k_r + NW'(1);
      end
      rlsv_pkg::S_X_A: u_nxt = t_r + CW'(1);
      rlsv_pkg::S_X_B: begin
        if (u_r >= n_act) t_nxt = t_r + CW'(1);
        else k_nxt = '0;
      end
      rlsv_pkg::S_X_K: begin
        if (k_r >= len_r[ti]) u_nxt = u_r + CW'(1);
        else l_nxt = '0;
      end
      rlsv_pkg::S_X_L: if (l_r >= len_r[ui]) k_nxt = k_r + NW'(1);
      rlsv_pkg::S_X_F1: rt_raddr = {ti, k_r};
      rlsv_pkg::S_X_F2: begin
        x_nxt = rt_q; rt_raddr = {ui, l_r};
      end
      rlsv_pkg::S_X_F3: begin
        y_nxt = rt_q; dm_raddr = x_r;
      end
      rlsv_pkg::S_X_F4: begin
        dx_nxt = dm_q; dm_raddr = y_r;
      end
      rlsv_pkg::S_X_F5: begin
        da_nxt = da_w[LW-1:0]; db_nxt = db_w[LW-1:0];
        if (da_w > {2'b0, cap_r} || db_w > {2'b0, cap_r}) l_nxt = l_r + NW'(1);
        else begin
          ct_nxt = ti; clen_nxt = len_r[ti]; ov_en_nxt = 1'b1;
          ov_pos_nxt = k_r; ov_val_nxt = y_r;
          p_nxt = '0; last_nxt = '0; acc_nxt = '0; ret_nxt = rlsv_pkg::S_X_CA;
        end
      end
      rlsv_pkg::S_X_CA: begin
        ca_nxt = acc_r;
        ct_nxt = ui; clen_nxt = len_r[ui]; ov_en_nxt = 1'b1;
        ov_pos_nxt = l_r; ov_val_nxt = x_r;
        p_nxt = '0; last_nxt = '0; acc_nxt = '0; ret_nxt = rlsv_pkg::S_X_EVAL;
      end
      rlsv_pkg::S_X_EVAL: begin
        if ({{(KW-AW){1'b0}}, csum} < osum) begin
          cost_nxt[ti] = {10'b0, ca_r};
          cost_nxt[ui] = {10'b0, acc_r};
          load_nxt[ti] = da_r;
          load_nxt[ui] = db_r;
          hit_nxt = 1'b1;
        end else l_nxt = l_r + NW'(1);
      end
      rlsv_pkg::S_X_W1: begin
        rt_we = 1'b1; rt_waddr = {ti, k_r}; rt_wdata = y_r;
      end
      rlsv_pkg::S_X_W2: begin
        rt_we = 1'b1; rt_waddr = {ui, l_r}; rt_wdata = x_r;
        l_nxt = l_r + NW'(1);
      end
      rlsv_pkg::S_C_ADDR: begin
        if (p_r == clen_r) ds_raddr = {last_r, NW'(0)};
        else rt_raddr = {ct_r, rlsv_pkg::trial_src(nbh_r, p_r, j_r, k_r)};
      end
      rlsv_pkg::S_C_NODE: begin
        ds_raddr = {last_r, node}; last_nxt = node;
      end
      rlsv_pkg::S_C_ACC: begin
        acc_nxt = acc_r + {{(AW-16){1'b0}}, ds_q};
        if (p_r != clen_r) p_nxt = p_r + NW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlsv_pkg::S_IDLE;
      nbh_r <= rlsv_pkg::NB_SWAP;
      out_valid_r <= 1'b0;
      cap_r <= '0;
      cnt_r <= CW'(1);
      for (int i = 0; i < rlsv_pkg::TRUCKS; i++) begin
        len_r[i] <= '0; cost_r[i] <= '0; load_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      nbh_r <= nbh_nxt;
      len_r <= len_nxt; cost_r <= cost_nxt; load_r <= load_nxt;
      if (cfg_we) begin
        if (cfg_index) cnt_r <= cfg_wdata[CW-1:0];
        else cap_r <= cfg_wdata;
      end
      if (state_r == rlsv_pkg::S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt; hit_r <= hit_nxt; any_r <= any_nxt; ld_one_r <= ld_one_nxt;
    t_r <= t_nxt; u_r <= u_nxt; j_r <= j_nxt; k_r <= k_nxt; l_r <= l_nxt;
    p_r <= p_nxt; last_r <= last_nxt; acc_r <= acc_nxt; ca_r <= ca_nxt;
    ct_r <= ct_nxt; clen_r <= clen_nxt; ov_en_r <= ov_en_nxt;
    ov_pos_r <= ov_pos_nxt; ov_val_r <= ov_val_nxt;
    x_r <= x_nxt; y_r <= y_nxt; sw_x_r <= sw_x_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    dx_r <= dx_nxt; da_r <= da_nxt; db_r <= db_nxt;
    res_client_r <= res_client_nxt; res_length_r <= res_length_nxt;
    res_cost_r <= res_cost_nxt; res_load_r <= res_load_nxt;
    res_imp_r <= res_imp_nxt; res_status_r <= res_status_nxt;
    if (state_r == rlsv_pkg::S_DONE && out_free) begin
      out_read_client <= res_client_r;
      out_read_length <= res_length_r;
      out_read_cost <= res_cost_r;
      out_read_load <= res_load_r;
      out_improved <= res_imp_r;
      out_status <= res_status_r;
    end
  end

  assign out_valid = out_valid_r;

  a_nbh_code: assert property (@(posedge clk) disable iff (!rst_n)
    nbh_r != 2'd3) else $error("neighborhood index out of range");
  a_idle_nbh: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rlsv_pkg::S_IDLE |-> nbh_r == rlsv_pkg::NB_SWAP)
    else $error("neighborhood not reset after run");
  a_imp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_improved |-> !out_status) else $error("improved with error status");
  a_cost_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rlsv_pkg::S_C_ADDR |-> p_r <= clen_r) else $error("cost walk past route end");
endmodule
`default_nettype wire
